/* rtl/plt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants for the packed length-type-value stream parser.
// ----------------------------------------------------------------------------
package plt_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TYPE   = 2'd1,
        PH_VALUE  = 2'd2,
        PH_IGNORE = 2'd3
    } phase_t;

    localparam logic [1:0] ROLE_HEADER  = 2'd0;
    localparam logic [1:0] ROLE_TYPE    = 2'd1;
    localparam logic [1:0] ROLE_VALUE   = 2'd2;
    localparam logic [1:0] ROLE_IGNORED = 2'd3;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] held_type;
        logic [7:0] held_length;
        logic [7:0] value_count;
        logic       error_seen;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] byte_role;
        logic [7:0] entry_type;
        logic [7:0] entry_length;
        logic       type_known;
        logic [7:0] value_index;
        logic       entry_end;
        logic       type_match;
        logic       parse_error;
        logic       frame_ok;
    } parse_result_t;

endpackage : plt_pkg
`default_nettype wire

/* rtl/plt_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plt_decode
// Decodes one frame byte against the parser state: header unpacking, length
// check, and the next parser state.
// ----------------------------------------------------------------------------
module plt_decode
    import plt_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 128
)
(
    input  wire parse_state_t  state,
    input  wire logic [7:0]    target_type,
    input  wire logic [7:0]    data_byte,
    input  wire logic [6:0]    bytes_after,
    output parse_state_t       state_next,
    output parse_result_t      result
);

    localparam logic [6:0] SAT_R =
        (MAX_FRAME_BYTES - 1 > 127) ? 7'd127 : 7'(MAX_FRAME_BYTES - 1);

    logic [6:0] r;
    logic       last;
    logic [7:0] lmask;
    logic [7:0] tmask;
    logic [2:0] b;
    logic       unpacked;
    logic [7:0] hdr_len;
    logic [7:0] hdr_type;
    logic [8:0] need;
    logic [7:0] vc_inc;

    assign r    = (bytes_after > SAT_R) ? SAT_R : bytes_after;
    assign last = (r == 7'd0);

    // length mask covers every bit up to the msb of the remaining count
    always_comb
    begin
        lmask = '0;
        b     = '0;
        for (int i = 0; i < 7; i++)
        begin
            lmask[i] = |(r >> i);
            if (r[i])
            begin
                b = 3'(i + 1);
            end
        end
    end

    assign tmask    = ~lmask;
    assign unpacked = ((data_byte & tmask) == tmask);
    assign hdr_len  = data_byte & lmask;
    assign hdr_type = 8'((data_byte & tmask) >> b);
    assign need     = {1'b0, hdr_len} + {8'd0, unpacked};
    assign vc_inc   = state.value_count + 8'd1;

    always_comb
    begin
        state_next = state;
        result     = '0;
        case (state.phase)
            PH_IGNORE:
            begin
                result.byte_role = ROLE_IGNORED;
                if (last)
                begin
                    state_next.error_seen = 1'b0;
                    state_next.phase      = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                result.byte_role = ROLE_HEADER;
                if (last)
                begin
                    result.entry_type     = data_byte;
                    result.type_known     = 1'b1;
                    result.entry_end      = 1'b1;
                    result.frame_ok       = ~state.error_seen;
                    state_next.error_seen = 1'b0;
                end
                else
                begin
                    result.entry_length = hdr_len;
                    result.type_known   = ~unpacked;
                    if (!unpacked)
                    begin
                        result.entry_type = hdr_type;
                    end
                    if (need > {2'b00, r})
                    begin
                        result.parse_error    = 1'b1;
                        state_next.error_seen = 1'b1;
                        state_next.phase      = PH_IGNORE;
                    end
                    else if (unpacked)
                    begin
                        state_next.held_length = hdr_len;
                        state_next.phase       = PH_TYPE;
                    end
                    else if (hdr_len == 8'd0)
                    begin
                        result.entry_end = 1'b1;
                    end
                    else
                    begin
                        state_next.held_type   = hdr_type;
                        state_next.held_length = hdr_len;
                        state_next.value_count = 8'd0;
                        state_next.phase       = PH_VALUE;
                    end
                end
            end
            PH_TYPE:
            begin
                result.byte_role       = ROLE_TYPE;
                result.entry_type      = data_byte;
                result.entry_length    = state.held_length;
                result.type_known      = 1'b1;
                state_next.held_type   = data_byte;
                state_next.value_count = 8'd0;
                if (state.held_length == 8'd0)
                begin
                    result.entry_end = 1'b1;
                    result.frame_ok  = last;
                    state_next.phase = PH_HEADER;
                end
                else if (last)
                begin
                    result.parse_error = 1'b1;
                    state_next.phase   = PH_HEADER;
                end
                else
                begin
                    state_next.phase = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                result.byte_role       = ROLE_VALUE;
                result.entry_type      = state.held_type;
                result.entry_length    = state.held_length;
                result.type_known      = 1'b1;
                result.value_index     = state.value_count;
                state_next.value_count = vc_inc;
                if (vc_inc >= state.held_length)
                begin
                    result.entry_end = 1'b1;
                    result.frame_ok  = last;
                    state_next.phase = PH_HEADER;
                end
                else if (last)
                begin
                    result.parse_error = 1'b1;
                    state_next.phase   = PH_HEADER;
                end
            end
            default:
            begin
                state_next.phase = PH_HEADER;
            end
        endcase
        result.type_match = result.type_known && (result.entry_type == target_type);
    end

endmodule : plt_decode
`default_nettype wire

/* rtl/packed_ltv_stream_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// packed_ltv_stream_parser
// Parses a frame's packed length-type-value list one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries data_byte and bytes_after, the
//   count of frame bytes that follow; bytes_after of 0 closes the frame.
//   Output channel (out_valid/out_ready) returns one result transaction per
//   input byte: its role, the entry type/length, value index, end-of-entry,
//   type match, parse error and frame status.
//   Config channel (cfg_valid/cfg_ready, cfg_data) writes target_type; it is
//   always ready and should be written only while the parser is idle.
//   The result is registered: it appears in the cycle after the byte is
//   taken. A new byte is taken every cycle while out_ready is high or no
//   result is held; the decode is a single pass of encode and mask logic
//   between the parser state and the result register. When the receiver
//   stalls, the held result stays put and in_ready drops until out_ready
//   returns; no byte is lost. Reset clears the parser to expect a header,
//   zeroes the held entry and clears target_type and the output valid.
// ----------------------------------------------------------------------------
module packed_ltv_stream_parser
    import plt_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic [6:0] bytes_after,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      byte_role,
    output logic [7:0]      entry_type,
    output logic [7:0]      entry_length,
    output logic            type_known,
    output logic [7:0]      value_index,
    output logic            entry_end,
    output logic            type_match,
    output logic            parse_error,
    output logic            frame_ok
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result_reg;
    parse_result_t result_next;
    logic [7:0]    target_type_reg;
    logic          out_valid_reg;
    logic          in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_fire   = in_valid & in_ready;

    plt_decode #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_decode (
        .state       (state_reg),
        .target_type (target_type_reg),
        .data_byte   (data_byte),
        .bytes_after (bytes_after),
        .state_next  (state_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '{phase: PH_HEADER, default: '0};
            target_type_reg <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                target_type_reg <= cfg_data;
            end
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_role    = result_reg.byte_role;
    assign entry_type   = result_reg.entry_type;
    assign entry_length = result_reg.entry_length;
    assign type_known   = result_reg.type_known;
    assign value_index  = result_reg.value_index;
    assign entry_end    = result_reg.entry_end;
    assign type_match   = result_reg.type_match;
    assign parse_error  = result_reg.parse_error;
    assign frame_ok     = result_reg.frame_ok;

endmodule : packed_ltv_stream_parser
`default_nettype wire

/* tb/ltv_result_checker.sv */
// ----------------------------------------------------------------------------
// ltv_result_checker
// Watches the config, input and result channels of the packed LTV parser.
// Each accepted byte is decoded by an independent parser model and the
// expected result is queued. Each accepted result is compared with the oldest
// queued one. The checker reports the open queue depth and the failure count.
// ----------------------------------------------------------------------------
module ltv_result_checker
    import plt_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic [6:0] bytes_after,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] byte_role,
    input  logic [7:0] entry_type,
    input  logic [7:0] entry_length,
    input  logic       type_known,
    input  logic [7:0] value_index,
    input  logic       entry_end,
    input  logic       type_match,
    input  logic       parse_error,
    input  logic       frame_ok,
    output int         pending,
    output int         fail_count
);

    parse_state_t  st;
    logic [7:0]    target_q;
    parse_result_t expected_results[$];
    int            errors;

    function automatic parse_result_t decode_ltv_byte(input logic [7:0] d,
                                                      input logic [6:0] after);
        parse_result_t res;
        int            r;
        int            nbits;
        int            vlen;
        logic [7:0]    lmask;
        logic [7:0]    tmask;
        logic          esc;
        logic          last;
        res = '0;
        r = int'(after);
        if (r > MAX_FRAME_BYTES - 1)
            r = MAX_FRAME_BYTES - 1;
        last = (r == 0);
        case (st.phase)
            PH_IGNORE:
            begin
                res.byte_role = ROLE_IGNORED;
                if (last)
                begin
                    st.error_seen = 1'b0;
                    st.phase = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                res.byte_role = ROLE_HEADER;
                if (last)
                begin
                    res.entry_type = d;
                    res.type_known = 1'b1;
                    res.entry_end  = 1'b1;
                    res.frame_ok   = !st.error_seen;
                    st.error_seen  = 1'b0;
                end
                else
                begin
                    nbits = $clog2(r + 1);
                    if (nbits >= 8)
                    begin
                        vlen = int'(d);
                        esc = 1'b1;
                    end
                    else
                    begin
                        lmask = 8'((1 << nbits) - 1);
                        tmask = ~lmask;
                        vlen = int'(d & lmask);
                        esc = ((d & tmask) == tmask);
                        if (!esc)
                            res.entry_type = (d & tmask) >> nbits;
                    end
                    res.entry_length = 8'(vlen);
                    res.type_known = !esc;
                    if (vlen + int'(esc) > r)
                    begin
                        res.parse_error = 1'b1;
                        st.error_seen = 1'b1;
                        st.phase = PH_IGNORE;
                    end
                    else if (esc)
                    begin
                        st.held_length = 8'(vlen);
                        st.phase = PH_TYPE;
                    end
                    else if (vlen == 0)
                        res.entry_end = 1'b1;
                    else
                    begin
                        st.held_type = res.entry_type;
                        st.held_length = 8'(vlen);
                        st.value_count = '0;
                        st.phase = PH_VALUE;
                    end
                end
            end
            PH_TYPE:
            begin
                res.byte_role = ROLE_TYPE;
                st.held_type = d;
                res.entry_type = d;
                res.entry_length = st.held_length;
                res.type_known = 1'b1;
                st.value_count = '0;
                if (st.held_length == 0)
                begin
                    res.entry_end = 1'b1;
                    res.frame_ok = last;
                    st.phase = PH_HEADER;
                end
                else if (last)
                begin
                    res.parse_error = 1'b1;
                    st.phase = PH_HEADER;
                end
                else
                    st.phase = PH_VALUE;
            end
            default:
            begin
                res.byte_role = ROLE_VALUE;
                res.entry_type = st.held_type;
                res.entry_length = st.held_length;
                res.type_known = 1'b1;
                res.value_index = st.value_count;
                st.value_count = st.value_count + 8'd1;
                if (st.value_count >= st.held_length)
                begin
                    res.entry_end = 1'b1;
                    res.frame_ok = last;
                    st.phase = PH_HEADER;
                end
                else if (last)
                begin
                    res.parse_error = 1'b1;
                    st.phase = PH_HEADER;
                end
            end
        endcase
        res.type_match = res.type_known && (res.entry_type == target_q);
        return res;
    endfunction

    function automatic string fmt_result(input parse_result_t x);
        return $sformatf("role=%0d type=%02h len=%0d known=%b idx=%0d end=%b match=%b err=%b ok=%b",
                         x.byte_role, x.entry_type, x.entry_length, x.type_known,
                         x.value_index, x.entry_end, x.type_match, x.parse_error,
                         x.frame_ok);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        parse_result_t got;
        parse_result_t want;
        if (!rst_n)
        begin
            st = '0;
            st.phase = PH_HEADER;
            target_q = '0;
            expected_results.delete();
            errors = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                target_q = cfg_data;
            if (in_valid && in_ready)
                expected_results.push_back(decode_ltv_byte(data_byte, bytes_after));
            if (out_valid && out_ready)
            begin
                got.byte_role    = byte_role;
                got.entry_type   = entry_type;
                got.entry_length = entry_length;
                got.type_known   = type_known;
                got.value_index  = value_index;
                got.entry_end    = entry_end;
                got.type_match   = type_match;
                got.parse_error  = parse_error;
                got.frame_ok     = frame_ok;
                if (expected_results.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result transaction: %s", fmt_result(got));
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("result mismatch\n  expected %s\n  actual   %s",
                                     fmt_result(want), fmt_result(got));
                        errors++;
                    end
                end
            end
            pending <= expected_results.size();
            fail_count <= errors;
        end
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the packed LTV stream parser. A directed set of
// frames covers packed, escaped, too-long and truncated entries, then random
// frames run under several target types with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    import plt_pkg::*;

    localparam int MAX_FRAME_BYTES = 128;
    localparam int RANDOM_ITEMS    = 1350;
    localparam int FRAME_CLEAN     = 0;
    localparam int FRAME_CUT       = 1;
    localparam int FRAME_NOISE     = 2;
    localparam int FRAME_SCRAMBLE  = 3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = '0;
    logic [6:0] bytes_after = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] byte_role;
    logic [7:0] entry_type;
    logic [7:0] entry_length;
    logic       type_known;
    logic [7:0] value_index;
    logic       entry_end;
    logic       type_match;
    logic       parse_error;
    logic       frame_ok;

    int         pending;
    int         fail_count;
    int         items = 0;
    bit         tail_quiet = 1'b0;
    logic [7:0] target_now = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    packed_ltv_stream_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .bytes_after (bytes_after),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_role   (byte_role),
        .entry_type  (entry_type),
        .entry_length(entry_length),
        .type_known  (type_known),
        .value_index (value_index),
        .entry_end   (entry_end),
        .type_match  (type_match),
        .parse_error (parse_error),
        .frame_ok    (frame_ok)
    );

    ltv_result_checker #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .bytes_after (bytes_after),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_role   (byte_role),
        .entry_type  (entry_type),
        .entry_length(entry_length),
        .type_known  (type_known),
        .value_index (value_index),
        .entry_end   (entry_end),
        .type_match  (type_match),
        .parse_error (parse_error),
        .frame_ok    (frame_ok),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    // receiver: ready runs with stall bursts, always ready in the tail
    initial
    begin : rx_pace
        forever
        begin
            out_ready <= 1'b1;
            if (tail_quiet)
                @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 30)) @(posedge clk);
                if (!tail_quiet && $urandom_range(0, 2) == 0)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge clk);
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic [6:0] n);
        if (!tail_quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        bytes_after <= n;
        do @(posedge clk); while (!in_ready);
        items++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_target(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        target_now = v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input int len, input int style);
        logic [7:0] fbytes[$];
        int         r;
        int         nb;
        int         vlen;
        int         t;
        int         ncut;
        while (fbytes.size() < len)
        begin
            r = len - 1 - fbytes.size();
            if (style == FRAME_NOISE || style == FRAME_SCRAMBLE || r == 0)
                fbytes.push_back(8'($urandom));
            else
            begin
                nb = $clog2(r + 1);
                if ($urandom_range(0, 1) == 1)
                begin
                    // escaped header, separate type byte
                    vlen = $urandom_range(0, 1) ? $urandom_range(0, r - 1)
                                                : $urandom_range(0, (r - 1 < 4) ? r - 1 : 4);
                    fbytes.push_back(8'((8'hFF << nb) | vlen));
                    fbytes.push_back($urandom_range(0, 1) ? target_now : 8'($urandom));
                end
                else
                begin
                    vlen = $urandom_range(0, 1) ? $urandom_range(0, r)
                                                : $urandom_range(0, (r < 4) ? r : 4);
                    t = $urandom_range(0, (1 << (8 - nb)) - 2);
                    if ($urandom_range(0, 1) == 1 && int'(target_now) <= (1 << (8 - nb)) - 2)
                        t = int'(target_now);
                    fbytes.push_back(8'((t << nb) | vlen));
                end
                repeat (vlen) fbytes.push_back(8'($urandom));
            end
        end
        ncut = (style == FRAME_CUT && len >= 2) ? $urandom_range(0, len - 2) : len - 1;
        for (int i = 0; i <= ncut; i++)
        begin
            if (i == ncut)
                push_byte(fbytes[i], 7'd0);
            else if (style == FRAME_SCRAMBLE)
                push_byte(fbytes[i], 7'($urandom_range(1, 127)));
            else
                push_byte(fbytes[i], 7'(len - 1 - i));
        end
    endtask

    initial
    begin : watchdog
        #3000000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int         len;
        int         style;
        logic [7:0] pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_target(8'hA5);
        push_byte(8'hA5, 7'd0);     // single-byte frame, matching type
        push_byte(8'h00, 7'd0);
        push_byte(8'h02, 7'd1);     // packed, zero length
        push_byte(8'hFF, 7'd0);
        push_byte(8'hFD, 7'd2);     // escape mask, one value byte
        push_byte(8'hA5, 7'd1);
        push_byte(8'hFF, 7'd0);
        push_byte(8'h03, 7'd2);     // length too long, rest ignored
        push_byte(8'h77, 7'd1);
        push_byte(8'h88, 7'd0);
        push_byte(8'h0A, 7'd3);     // frame ends inside the value
        push_byte(8'h11, 7'd0);
        push_byte(8'hF9, 7'd4);     // frame ends on the type byte
        push_byte(8'h5A, 7'd0);
        push_byte(8'hF8, 7'd5);     // escaped zero-length entry
        push_byte(8'h11, 7'd4);
        push_byte(8'h00, 7'd3);
        push_byte(8'h7C, 7'd2);
        push_byte(8'hE5, 7'd1);
        push_byte(8'hC3, 7'd0);
        push_byte(8'h80, 7'd127);   // widest count
        push_byte(8'hFF, 7'd126);
        push_byte(8'h7F, 7'd125);
        push_byte(8'h00, 7'd0);
        drain_results();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: pick = 8'h00;
                1: pick = 8'hFF;
                2: pick = 8'h01;
                3: pick = 8'h7E;
                default: pick = 8'($urandom);
            endcase
            set_target(pick);
            while (items < 24 + (ph + 1) * (RANDOM_ITEMS / 6))
            begin
                if (items >= 24 + RANDOM_ITEMS - 150)
                    tail_quiet <= 1'b1;
                style = $urandom_range(0, 9);
                if (style > FRAME_SCRAMBLE)
                    style = FRAME_CLEAN;
                if (style == FRAME_SCRAMBLE)
                    len = $urandom_range(1, 8);
                else if ($urandom_range(0, 15) == 0)
                    len = $urandom_range(64, MAX_FRAME_BYTES);
                else
                    len = $urandom_range(1, 24);
                send_frame(len, style);
            end
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/plt_pkg.sv
rtl/plt_decode.sv
rtl/packed_ltv_stream_parser.sv
tb/ltv_result_checker.sv
tb/tb.sv
